// ===== rtl/trs_pkg.sv =====
`default_nettype none
package trs_pkg;

  localparam int MAX_HITS = 512;
  localparam int ADDR_W   = $clog2(MAX_HITS);
  localparam int CNT_W    = $clog2(MAX_HITS + 1);
  localparam int POS_W    = 14;
  localparam int DIFF_W   = POS_W + 1;
  localparam int TIME_W   = 20;
  localparam int RES_W    = 21;
  localparam int SUM_W    = RES_W + ADDR_W + 1;
  localparam int MUL_W    = 22;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 2 * MUL_W - 1 + ADDR_W;
  localparam int D2_W     = 30;
  localparam int DIST_W   = 15;
  localparam int TOF_W    = 13;
  localparam int RAD_W    = ACC_W + (ACC_W % 2);
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int IT_W     = $clog2(ROOT_W + 1);
  localparam int DC_W     = $clog2(ACC_W + 1);
  localparam int CFG_W    = 2;

  // round(2^16 * 4 / 21.5833): 1/16 cm to 1/64 ns
  localparam logic [13:0] TOF_K = 14'd12146;

  typedef enum logic [CFG_W-1:0] {
    REG_VX = 2'd0,
    REG_VY = 2'd1,
    REG_VZ = 2'd2
  } cfg_reg_e;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SQ    = 12'b0000_0000_0010,
    S_DSQRT = 12'b0000_0000_0100,
    S_TOF   = 12'b0000_0000_1000,
    S_STORE = 12'b0000_0001_0000,
    S_DIV   = 12'b0000_0010_0000,
    S_RD    = 12'b0000_0100_0000,
    S_MUL   = 12'b0000_1000_0000,
    S_ACC   = 12'b0001_0000_0000,
    S_VDIV  = 12'b0010_0000_0000,
    S_VSQRT = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } st_e;

  typedef struct packed {
    logic            start;
    logic [IT_W-1:0] iters;
  } sqrt_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/time_residual_spread.sv =====
`default_nettype none
// Time residual spread of a hit cluster against a trial vertex.
// Config: write vertex_x/y/z (index 0..2) on cfg_valid_i/cfg_ready_o while idle;
// cfg_ready_o is always high, other indexes are ignored.
// Input channel: one hit per transfer (in_valid_i, in_stall_o). in_stall_o is
// high while a hit is in work. A hit runs through these steps before the next
// one is taken: the accepting cycle, the squares on the shared multiplier,
// a 15-step square root plus a launch and a done cycle, one multiply for time
// of flight and a store cycle.
// A hit with last_hit set also closes the cluster: a 52-step divide for the
// mean, a read, a multiply and an accumulate per stored hit over the residual
// memory, a 52-step divide for the variance and a 26-step square root plus a
// launch and a done cycle.
// Output channel: one result per cluster (out_valid_o, out_stall_i) from an
// output register; the next cluster may start while it waits. If a new
// result is ready and the old one is still stalled, the block holds.
// Up to 512 hits are stored; later ones are dropped and flagged.
// Reset clears the vertex, counters and flags; the residual memory is not
// cleared and is only read where written in the current cluster.
module time_residual_spread (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [trs_pkg::CFG_W-1:0]    cfg_index_i,
  input  wire logic [trs_pkg::POS_W-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [trs_pkg::POS_W-1:0]  sensor_x_i,
  input  wire logic signed [trs_pkg::POS_W-1:0]  sensor_y_i,
  input  wire logic signed [trs_pkg::POS_W-1:0]  sensor_z_i,
  input  wire logic signed [trs_pkg::TIME_W-1:0] hit_time_i,
  input  wire logic                         last_hit_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [trs_pkg::TIME_W-1:0] mean_residual_o,
  output logic [trs_pkg::TIME_W-1:0]        spread_o,
  output logic [trs_pkg::CNT_W-1:0]         hits_used_o,
  output logic                              overflowed_o
);
  import trs_pkg::*;

  st_e state_q, state_d;

  logic signed [POS_W-1:0]  vx_q, vy_q, vz_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic signed [TIME_W-1:0] t_q;
  logic                     last_q;
  logic [1:0]               step_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p, prod_q;
  logic [D2_W-1:0]          d2_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [SUM_W-1:0]  sum_q, sum_nx, mag;
  logic [CNT_W-1:0]         cnt_q, cnt_nx, n_q, idx_q;
  logic                     ovf_q, full, neg_q;
  logic [ACC_W-1:0]         divq_q, divq_nx, acc_q, acc_nx;
  logic [CNT_W:0]           drem_q, drem_sh, drem_nx;
  logic                     dge;
  logic [DC_W-1:0]          dcnt_q;
  logic signed [RES_W-1:0]  mean_q, mean_nx, rdata_q, res;
  logic signed [MUL_W-1:0]  diff;
  logic [D2_W-1:0]          tof_sum;
  logic [TOF_W-1:0]         tof;
  logic                     launched_q;
  sqrt_ctl_t                sq_ctl;
  logic [RAD_W-1:0]         sq_rad;
  logic                     sq_done;
  logic [ROOT_W-1:0]        sq_root;
  logic signed [RES_W-1:0]  mem [MAX_HITS];
  logic                     out_valid_q, out_free;
  logic signed [TIME_W-1:0] mean_out_q;
  logic [TIME_W-1:0]        spread_q, spr_out_q;
  logic [CNT_W-1:0]         hits_out_q;
  logic                     ovf_out_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        case (step_q)
          2'd0:    mul_a = MUL_W'(dx_q);
          2'd1:    mul_a = MUL_W'(dy_q);
          default: mul_a = MUL_W'(dz_q);
        endcase
        mul_b = mul_a;
      end
      S_TOF: begin
        mul_a = $signed(MUL_W'(dist_q));
        mul_b = $signed(MUL_W'(TOF_K));
      end
      S_MUL: begin
        mul_a = diff;
        mul_b = diff;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign diff  = MUL_W'(rdata_q) - MUL_W'(mean_q);

  always_comb begin
    tof_sum = D2_W'(prod_q[D2_W-2:0]) + D2_W'(32768);
    tof     = tof_sum[D2_W-2:16];
    res     = RES_W'(t_q) - $signed(RES_W'(tof));
    full    = cnt_q == CNT_W'(MAX_HITS);
    sum_nx  = full ? sum_q : sum_q + SUM_W'(res);
    cnt_nx  = full ? cnt_q : cnt_q + CNT_W'(1);
    mag     = sum_nx[SUM_W-1] ? -sum_nx : sum_nx;
    acc_nx  = acc_q + ACC_W'($unsigned(prod_q));
  end

  always_comb begin
    drem_sh = {drem_q[CNT_W-1:0], divq_q[ACC_W-1]};
    dge     = drem_sh >= {1'b0, n_q};
    drem_nx = dge ? drem_sh - {1'b0, n_q} : drem_sh;
    divq_nx = {divq_q[ACC_W-2:0], dge};
    mean_nx = neg_q ? -$signed(divq_nx[RES_W-1:0]) : $signed(divq_nx[RES_W-1:0]);
  end

  always_comb begin
    sq_ctl.start = (state_q == S_DSQRT || state_q == S_VSQRT) && !launched_q;
    sq_ctl.iters = (state_q == S_DSQRT) ? IT_W'(D2_W / 2) : IT_W'(ROOT_W);
    sq_rad       = (state_q == S_DSQRT) ? {d2_q, (RAD_W - D2_W)'(0)} : RAD_W'(divq_q);
  end

  trs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .rad_i  (sq_rad),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SQ;
      S_SQ:    if (step_q == 2'd3) state_d = S_DSQRT;
      S_DSQRT: if (sq_done) state_d = S_TOF;
      S_TOF:   state_d = S_STORE;
      S_STORE: state_d = last_q ? S_DIV : S_IDLE;
      S_DIV:   if (dcnt_q == DC_W'(1)) state_d = S_RD;
      S_RD:    state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = (idx_q + CNT_W'(1) == n_q) ? S_VDIV : S_RD;
      S_VDIV:  if (dcnt_q == DC_W'(1)) state_d = S_VSQRT;
      S_VSQRT: if (sq_done) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_STORE && !full) begin
      mem[cnt_q[ADDR_W-1:0]] <= res;
    end
    rdata_q <= mem[idx_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      vx_q       <= '0;
      vy_q       <= '0;
      vz_q       <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      step_q     <= '0;
      dcnt_q     <= '0;
      idx_q      <= '0;
      launched_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_VX:  vx_q <= cfg_data_i;
          REG_VY:  vy_q <= cfg_data_i;
          REG_VZ:  vz_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: step_q <= '0;
        S_SQ:   step_q <= step_q + 2'd1;
        S_DSQRT, S_VSQRT: begin
          launched_q <= !sq_done;
        end
        S_STORE: begin
          sum_q <= sum_nx;
          cnt_q <= cnt_nx;
          if (full) ovf_q <= 1'b1;
          dcnt_q <= DC_W'(ACC_W);
        end
        S_DIV: begin
          dcnt_q <= dcnt_q - DC_W'(1);
          idx_q  <= '0;
        end
        S_ACC: begin
          idx_q  <= idx_q + CNT_W'(1);
          dcnt_q <= DC_W'(ACC_W);
        end
        S_VDIV: dcnt_q <= dcnt_q - DC_W'(1);
        S_OUT: begin
          if (out_free) begin
            sum_q       <= '0;
            cnt_q       <= '0;
            ovf_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        dx_q   <= DIFF_W'(sensor_x_i) - DIFF_W'(vx_q);
        dy_q   <= DIFF_W'(sensor_y_i) - DIFF_W'(vy_q);
        dz_q   <= DIFF_W'(sensor_z_i) - DIFF_W'(vz_q);
        t_q    <= hit_time_i;
        last_q <= last_hit_i;
        d2_q   <= '0;
      end
      S_SQ: begin
        prod_q <= mul_p;
        if (step_q != 2'd0) d2_q <= d2_q + prod_q[D2_W-1:0];
      end
      S_DSQRT: if (sq_done) dist_q <= sq_root[DIST_W-1:0];
      S_TOF:   prod_q <= mul_p;
      S_STORE: begin
        n_q    <= cnt_nx;
        neg_q  <= sum_nx[SUM_W-1];
        divq_q <= ACC_W'($unsigned(mag)) + ACC_W'(cnt_nx >> 1);
        drem_q <= '0;
      end
      S_DIV: begin
        divq_q <= divq_nx;
        drem_q <= drem_nx;
        mean_q <= mean_nx;
        acc_q  <= '0;
      end
      S_MUL: prod_q <= mul_p;
      S_ACC: begin
        acc_q  <= acc_nx;
        divq_q <= acc_nx;
        drem_q <= '0;
      end
      S_VDIV: begin
        divq_q <= divq_nx;
        drem_q <= drem_nx;
      end
      S_VSQRT: begin
        if (sq_done) begin
          spread_q <= (sq_root > ROOT_W'({TIME_W{1'b1}})) ? {TIME_W{1'b1}}
                                                           : sq_root[TIME_W-1:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          if (mean_q > RES_W'(524287)) begin
            mean_out_q <= 20'sh7FFFF;
          end else if (mean_q < -RES_W'(524288)) begin
            mean_out_q <= 20'sh80000;
          end else begin
            mean_out_q <= mean_q[TIME_W-1:0];
          end
          spr_out_q  <= spread_q;
          hits_out_q <= n_q;
          ovf_out_q  <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign mean_residual_o = mean_out_q;
  assign spread_o        = spr_out_q;
  assign hits_used_o     = hits_out_q;
  assign overflowed_o    = ovf_out_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_HITS))
    else $error("hit count beyond capacity");
  a_out_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_free |=> out_valid_q && cnt_q == '0 && !ovf_q)
    else $error("cluster not closed on result");
  a_sqrt_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_DSQRT || state_q == S_VSQRT))
    else $error("sqrt result outside its states");
`endif
endmodule
`default_nettype wire

// ===== rtl/trs_sqrt.sv =====
`default_nettype none
module trs_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire trs_pkg::sqrt_ctl_t        ctl_i,
  input  wire logic [trs_pkg::RAD_W-1:0] rad_i,
  output logic                           done_o,
  output logic [trs_pkg::ROOT_W-1:0]     root_o
);
  import trs_pkg::*;

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [IT_W-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctl_i.start) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= ctl_i.iters;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
      cnt_q  <= cnt_q - IT_W'(1);
      if (cnt_q == IT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q)
    else $error("sqrt restarted while busy");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == IT_W'(1) && !ctl_i.start |=> done_o && !busy_q)
    else $error("sqrt did not finish");
`endif
endmodule
`default_nettype wire
